// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks on the note pairing table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also checks the reset itself.
`define CHK_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mnp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note pairing package
// Widths, codes, beat structures and the sequencer state type.
// ----------------------------------------------------------------------------
package mnp_pkg;

   // Default sizing of the pending table and the internal beat width.
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int BEAT_BITS_DEF   = 32;

   // Field widths on the ports.
   localparam int PITCH_W   = 7;
   localparam int VEL_W     = 7;
   localparam int PBEAT_W   = 32;
   localparam int MIN_DUR_W = 16;

   // Packed stream widths; the data widths are padded to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 80;

   // Smallest duration after reset: 0.01 beat in Q16.16.
   localparam logic [MIN_DUR_W-1:0] MIN_DUR_RESET = 16'd655;

   // Action codes.
   localparam logic [1:0] ACT_MIDI   = 2'd0;
   localparam logic [1:0] ACT_START  = 2'd1;
   localparam logic [1:0] ACT_STOP   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Message kind codes.
   localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [1:0] KIND_OTHER    = 2'd2;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   // One request beat.
   typedef struct packed {
      logic [PBEAT_W-1:0] beat_now;
      logic [VEL_W-1:0]   velocity;
      logic [PITCH_W-1:0] pitch;
      logic [1:0]         kind;
      logic [1:0]         action;
   } req_beat_type;

   // One result beat.
   typedef struct packed {
      logic               last;
      logic               dropped;
      logic [PBEAT_W-1:0] duration;
      logic [PBEAT_W-1:0] start;
      logic [VEL_W-1:0]   velocity;
      logic [PITCH_W-1:0] pitch;
   } rsp_beat_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_NOTE_OUT,
      ST_SHIFT,
      ST_FLUSH,
      ST_DROP
   } seq_state_type;

endpackage

// File: hw/rtl/mnp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mnp_ram #(
   parameter int WIDTH = 46,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mnp_seq.sv
// ----------------------------------------------------------------------------
// Note pairing sequencer
// Decodes a request, then appends, searches, compacts or flushes the table, or reports a drop.
// ----------------------------------------------------------------------------
module mnp_seq #(
   parameter int TABLE_DEPTH = 32,
   parameter int BEAT_BITS = 32,
   parameter int ENTRY_W = 14 + BEAT_BITS,
   parameter int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  mnp_pkg::req_beat_type          req_beat,
   input  logic [mnp_pkg::MIN_DUR_W-1:0]  min_dur,
   input  logic                           out_free,
   output logic                           out_load,
   output mnp_pkg::rsp_beat_type          out_beat,
   output logic                           ram_wr_en,
   output logic [ADDR_W-1:0]              ram_wr_addr,
   output logic [ENTRY_W-1:0]             ram_wr_data,
   output logic                           ram_rd_en,
   output logic [ADDR_W-1:0]              ram_rd_addr,
   input  logic [ENTRY_W-1:0]             ram_rd_data
);

   import mnp_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   seq_state_type      state_ff, state_in;
   req_beat_type       req_ff, req_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rec_ff, rec_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic               more_ff, more_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  addr_q_ff, addr_q_in;
   logic [CNT_W-1:0]   src_ff, src_in;
   logic [CNT_W-1:0]   fl_ff, fl_in;

   logic [PITCH_W-1:0]   ent_pitch;
   logic [VEL_W-1:0]     ent_vel;
   logic [BEAT_BITS-1:0] ent_start;
   logic [BEAT_BITS-1:0] now_beat;
   logic [BEAT_BITS-1:0] min_beat;
   logic [BEAT_BITS-1:0] diff;
   logic [BEAT_BITS-1:0] dur;
   logic [CNT_W-1:0]     count_dec;
   logic [CNT_W-1:0]     fl_inc;
   logic                 is_note_msg;
   logic                 is_note_on;
   logic                 table_full;
   logic                 hit;
   logic                 shift_rd;

   // Entry fields from the RAM read data.
   assign ent_pitch = ram_rd_data[PITCH_W-1:0];
   assign ent_vel   = ram_rd_data[PITCH_W+VEL_W-1:PITCH_W];
   assign ent_start = ram_rd_data[ENTRY_W-1:PITCH_W+VEL_W];

   // Note length: clamp a negative span to zero, then raise to the minimum.
   assign now_beat = BEAT_BITS'(req_ff.beat_now);
   assign min_beat = BEAT_BITS'(min_dur);
   assign diff     = (now_beat >= ent_start) ? (now_beat - ent_start) : '0;
   assign dur      = (diff < min_beat) ? min_beat : diff;

   // Request classification.
   assign is_note_msg = (req_ff.action == ACT_MIDI) && rec_ff &&
                        ((req_ff.kind == KIND_NOTE_ON) || (req_ff.kind == KIND_NOTE_OFF));
   assign is_note_on  = (req_ff.kind == KIND_NOTE_ON) && (req_ff.velocity != '0);
   assign table_full  = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign count_dec   = count_ff - CNT_W'(1);
   assign fl_inc      = fl_ff + CNT_W'(1);
   assign hit         = pend_ff && (ent_pitch == req_ff.pitch);
   assign shift_rd    = (src_ff < count_ff);

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rec_ff   <= 1'b0;
         more_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rec_ff   <= rec_in;
         more_ff  <= more_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload and pointer registers.
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      scan_ff   <= scan_in;
      addr_q_ff <= addr_q_in;
      src_ff    <= src_in;
      fl_ff     <= fl_in;
   end

   // Next state, RAM accesses and result loads.
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      rec_in    = rec_ff;
      scan_in   = scan_ff;
      more_in   = more_ff;
      pend_in   = pend_ff;
      addr_q_in = addr_q_ff;
      src_in    = src_ff;
      fl_in     = fl_ff;

      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[ADDR_W-1:0];
      ram_wr_data = {now_beat, req_ff.velocity, req_ff.pitch};
      ram_rd_en   = 1'b0;
      ram_rd_addr = scan_ff;

      out_load          = 1'b0;
      out_beat.pitch    = ent_pitch;
      out_beat.velocity = ent_vel;
      out_beat.start    = PBEAT_W'(ent_start);
      out_beat.duration = PBEAT_W'(dur);
      out_beat.dropped  = 1'b0;
      out_beat.last     = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_beat;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_IDLE;
            if (req_ff.action == ACT_START) begin
               count_in = '0;
               rec_in   = 1'b1;
            end else if (req_ff.action == ACT_STOP) begin
               if (rec_ff) begin
                  if (count_ff == '0) begin
                     rec_in = 1'b0;
                  end else begin
                     // Read the oldest entry to start the flush.
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     fl_in       = '0;
                     state_in    = ST_FLUSH;
                  end
               end
            end else if (is_note_msg) begin
               if (is_note_on) begin
                  if (table_full) begin
                     state_in = ST_DROP;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end else if (count_ff != '0) begin
                  // Search from the newest entry down.
                  scan_in  = count_dec[ADDR_W-1:0];
                  more_in  = 1'b1;
                  pend_in  = 1'b0;
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_DROP: begin
            if (out_free) begin
               out_load          = 1'b1;
               out_beat.pitch    = req_ff.pitch;
               out_beat.velocity = req_ff.velocity;
               out_beat.start    = PBEAT_W'(now_beat);
               out_beat.duration = '0;
               out_beat.dropped  = 1'b1;
               state_in          = ST_IDLE;
            end
         end

         ST_SEARCH: begin
            // One read issued per cycle; the compare sees the previous read.
            if (hit) begin
               pend_in  = 1'b0;
               state_in = ST_NOTE_OUT;
            end else if (more_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_ff;
               pend_in     = 1'b1;
               addr_q_in   = scan_ff;
               if (scan_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  scan_in = scan_ff - ADDR_W'(1);
               end
            end else begin
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         ST_NOTE_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               src_in   = CNT_W'(addr_q_ff) + CNT_W'(1);
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // Move each newer entry down by one place, keeping order.
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = addr_q_ff - ADDR_W'(1);
               ram_wr_data = ram_rd_data;
            end
            if (shift_rd) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = src_ff[ADDR_W-1:0];
               addr_q_in   = src_ff[ADDR_W-1:0];
               src_in      = src_ff + CNT_W'(1);
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (!shift_rd && !pend_ff) begin
               count_in = count_dec;
               state_in = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            // Emit oldest first; the next read overlaps the current beat.
            if (out_free) begin
               out_load      = 1'b1;
               out_beat.last = (fl_inc == count_ff);
               if (fl_inc == count_ff) begin
                  count_in = '0;
                  rec_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = fl_inc[ADDR_W-1:0];
                  fl_in       = fl_inc;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/midi_note_pairing_table_unit.sv
// ----------------------------------------------------------------------------
// MIDI note pairing table unit
// Pairs note-ons with note-offs in a pending table held in RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Beat contents
//   req       in          one MIDI message, start or stop action
//   rsp       out         one completed or dropped note
//   csr       in          write of min_duration
//
// An item is taken while idle and decoded in the next; start, stored note-on and
// ignored messages then finish. A note-off scans the table newest first, one
// entry per cycle through the RAM read port, then moves the newer entries
// down one place per cycle. A stop emits one pending note per cycle while the
// result register is free. Reset clears the state and the result register; the
// table needs no clearing. A stalled result holds the sequencer only when
// another result is ready to be loaded.
// ----------------------------------------------------------------------------
module midi_note_pairing_table_unit #(
   parameter int TABLE_DEPTH = mnp_pkg::TABLE_DEPTH_DEF,
   parameter int BEAT_BITS = mnp_pkg::BEAT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write of min_duration.
   input  logic                            csr_wr_en,
   input  logic [mnp_pkg::MIN_DUR_W-1:0]   csr_wr_data,
   // Request stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: note_pitch, note_velocity, beat_now, zero pad
   input  logic [mnp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: action, message_kind
   input  logic [mnp_pkg::REQ_USER_W-1:0]  req_tuser,
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: out_pitch, out_velocity, out_start, out_duration, zero pad
   output logic [mnp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: dropped
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   import mnp_pkg::*;

   localparam int ENTRY_W = PITCH_W + VEL_W + BEAT_BITS;
   localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [MIN_DUR_W-1:0] min_dur_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         rsp_ff, rsp_in;
   req_beat_type         req_beat;
   rsp_beat_type         out_beat;
   logic                 out_load;
   logic                 out_free;
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dur_ff <= MIN_DUR_RESET;
      end else if (csr_wr_en) begin
         min_dur_ff <= csr_wr_data;
      end
   end

   // Unpack the request beat.
   always_comb begin
      req_beat.action   = req_tuser[1:0];
      req_beat.kind     = req_tuser[3:2];
      req_beat.pitch    = req_tdata[PITCH_W-1:0];
      req_beat.velocity = req_tdata[PITCH_W+VEL_W-1:PITCH_W];
      req_beat.beat_now = req_tdata[PITCH_W+VEL_W+PBEAT_W-1:PITCH_W+VEL_W];
   end

   // Result register: loads when empty or when its beat leaves.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_in       = out_beat;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.duration, rsp_ff.start, rsp_ff.velocity, rsp_ff.pitch};
   assign rsp_tuser  = rsp_ff.dropped;
   assign rsp_tlast  = rsp_ff.last;

   // Sequencer.
   mnp_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .BEAT_BITS   (BEAT_BITS),
      .ENTRY_W     (ENTRY_W),
      .ADDR_W      (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_beat    (req_beat),
      .min_dur     (min_dur_ff),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_beat    (out_beat),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // Pending note table.
   mnp_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// File: hw/rtl/mnp_checker.sv
// ----------------------------------------------------------------------------
// Note pairing port checker
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mnp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            csr_wr_en,
   input logic [mnp_pkg::MIN_DUR_W-1:0]   csr_wr_data,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [mnp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic [mnp_pkg::REQ_USER_W-1:0]  req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mnp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);

   // A stalled result beat keeps its contents.
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
      "result beat changed while stalled")

   // Reset leaves no result pending.
   `CHK_NEXT_ALWAYS(a_rst_empty, clock, reset, !rsp_tvalid,
      "result valid right after reset")

   // A dropped note-on is the only result of its message.
   `CHK_IMPLY(a_drop_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast,
      "dropped beat without last")

   // A dropped note-on reports no duration.
   `CHK_IMPLY(a_drop_dur, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tdata[77:46] == 32'd0, "dropped beat with a duration")

endmodule

bind midi_note_pairing_table_unit mnp_checker u_mnp_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Note pairing table unit testbench
// Drives MIDI messages, start and stop actions into the unit and checks every
// completed or dropped note against a pairing predictor kept in this file.
// A short directed run covers the corner cases, then random recording
// sessions run under several min_duration settings with stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import mnp_pkg::*;

   localparam int NOTE_SLOTS = TABLE_DEPTH_DEF;
   localparam int PHASE_ITEMS = 72;
   localparam int SETTLE_CYCLES = 2 * NOTE_SLOTS + 40;

   // One pending note as the predictor holds it.
   typedef struct {
      logic [PITCH_W-1:0] pitch;
      logic [VEL_W-1:0]   velocity;
      logic [PBEAT_W-1:0] start;
   } held_note_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [MIN_DUR_W-1:0]   csr_wr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [REQ_USER_W-1:0]  req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // Stimulus and prediction state.
   req_beat_type           msg_queue[$];
   req_beat_type           msg_on_bus;
   rsp_beat_type           notes_expected[$];
   held_note_type          held_notes[$];
   logic                   armed = 1'b0;
   logic [MIN_DUR_W-1:0]   min_dur = MIN_DUR_RESET;
   logic [PBEAT_W-1:0]     beat_cursor = '0;
   bit                     calm = 1'b0;
   int                     send_gap = 0;
   int                     recv_stall = 0;
   int                     failures = 0;
   int                     planned = 0;
   int                     noise_planned = 0;
   int                     msgs_taken = 0;
   int                     notes_seen = 0;
   int                     notes_flushed = 0;
   int                     notes_dropped = 0;

   midi_note_pairing_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Duration of a note ending at now, never below the current minimum.
   function automatic logic [PBEAT_W-1:0] held_length(input logic [PBEAT_W-1:0] now,
                                                       input logic [PBEAT_W-1:0] start);
      logic [PBEAT_W-1:0] span;
      span = (now >= start) ? now - start : '0;
      if (span < PBEAT_W'(min_dur))
         span = PBEAT_W'(min_dur);
      return span;
   endfunction

   function automatic rsp_beat_type note_result(input held_note_type n,
                                                input logic [PBEAT_W-1:0] dur,
                                                input logic drop, input logic fin);
      rsp_beat_type r;
      r.pitch    = n.pitch;
      r.velocity = n.velocity;
      r.start    = n.start;
      r.duration = dur;
      r.dropped  = drop;
      r.last     = fin;
      return r;
   endfunction

   // Pairing predictor: updates the pending table and queues the notes due.
   task automatic pair_notes(input req_beat_type m);
      held_note_type n;
      int            hit;
      n.pitch    = m.pitch;
      n.velocity = m.velocity;
      n.start    = m.beat_now;
      hit = -1;
      case (m.action)
         ACT_START: begin
            held_notes.delete();
            armed = 1'b1;
         end
         ACT_STOP: begin
            if (armed) begin
               foreach (held_notes[i]) begin
                  notes_expected.push_back(note_result(held_notes[i],
                     held_length(m.beat_now, held_notes[i].start), 1'b0,
                     i == held_notes.size() - 1));
                  notes_flushed++;
               end
               held_notes.delete();
               armed = 1'b0;
            end
         end
         ACT_MIDI: begin
            if (armed && m.kind == KIND_NOTE_ON && m.velocity != 0) begin
               // A full table drops the note and reports it once.
               if (held_notes.size() >= NOTE_SLOTS) begin
                  notes_expected.push_back(note_result(n, '0, 1'b1, 1'b1));
                  notes_dropped++;
               end else begin
                  held_notes.push_back(n);
               end
            end else if (armed && (m.kind == KIND_NOTE_ON || m.kind == KIND_NOTE_OFF)) begin
               // Note-off: newest matching pitch wins.
               for (int i = held_notes.size() - 1; i >= 0 && hit < 0; i--)
                  if (held_notes[i].pitch == m.pitch)
                     hit = i;
               if (hit >= 0) begin
                  notes_expected.push_back(note_result(held_notes[hit],
                     held_length(m.beat_now, held_notes[hit].start), 1'b0, 1'b1));
                  held_notes.delete(hit);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Request driver with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pair_notes(msg_on_bus);
            msgs_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (msg_queue.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 9);
               req_tvalid <= 1'b0;
            end else if (msg_queue.size() > 0) begin
               msg_on_bus = msg_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, msg_on_bus.beat_now, msg_on_bus.velocity,
                              msg_on_bus.pitch};
               req_tuser  <= {msg_on_bus.kind, msg_on_bus.action};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random stall bursts.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            notes_seen++;
            if (notes_expected.size() == 0) begin
               $error("unexpected result beat: pitch %0d start %0h",
                      rsp_tdata[6:0], rsp_tdata[45:14]);
               failures++;
            end else begin
               want = notes_expected.pop_front();
               if (rsp_tdata[6:0] !== want.pitch) begin
                  $error("out_pitch: expected %0d, got %0d", want.pitch, rsp_tdata[6:0]);
                  failures++;
               end
               if (rsp_tdata[13:7] !== want.velocity) begin
                  $error("out_velocity: expected %0d, got %0d", want.velocity,
                         rsp_tdata[13:7]);
                  failures++;
               end
               if (rsp_tdata[45:14] !== want.start) begin
                  $error("out_start: expected %0h, got %0h", want.start, rsp_tdata[45:14]);
                  failures++;
               end
               if (rsp_tdata[77:46] !== want.duration) begin
                  $error("out_duration: expected %0h, got %0h", want.duration,
                         rsp_tdata[77:46]);
                  failures++;
               end
               if (rsp_tuser !== want.dropped) begin
                  $error("dropped: expected %0b, got %0b", want.dropped, rsp_tuser);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_msg(input logic [1:0] act, input logic [1:0] knd,
                            input logic [PITCH_W-1:0] p, input logic [VEL_W-1:0] v,
                            input logic [PBEAT_W-1:0] b);
      req_beat_type m;
      m.action   = act;
      m.kind     = knd;
      m.pitch    = p;
      m.velocity = v;
      m.beat_now = b;
      msg_queue.push_back(m);
      planned++;
   endtask

   // Transport mostly moves forward; now and then it jumps anywhere.
   function automatic logic [PBEAT_W-1:0] next_beat();
      if ($urandom_range(0, 11) == 0)
         beat_cursor = $urandom;
      else
         beat_cursor = beat_cursor + $urandom_range(0, 'h30000);
      return beat_cursor;
   endfunction

   // One recording session; a filling session overflows the table first.
   task automatic queue_session(input bit fill);
      logic [PITCH_W-1:0] pool[4];
      int                 n_ev;
      int                 r;
      foreach (pool[i])
         pool[i] = PITCH_W'($urandom_range(0, 127));
      queue_msg(ACT_START, 2'($urandom_range(0, 3)), PITCH_W'($urandom_range(0, 127)),
                VEL_W'($urandom_range(0, 127)), $urandom);
      if (fill) begin
         repeat (NOTE_SLOTS + $urandom_range(1, 4))
            queue_msg(ACT_MIDI, KIND_NOTE_ON,
                      $urandom_range(0, 1) ? pool[2'($urandom_range(0, 3))] :
                      PITCH_W'($urandom_range(0, 127)),
                      VEL_W'($urandom_range(1, 127)), next_beat());
      end
      n_ev = $urandom_range(2, 14);
      repeat (n_ev) begin
         r = $urandom_range(0, 9);
         if (r < 5)
            queue_msg(ACT_MIDI, KIND_NOTE_ON, pool[2'($urandom_range(0, 3))],
                      VEL_W'($urandom_range(1, 127)), next_beat());
         else if (r < 8)
            queue_msg(ACT_MIDI, KIND_NOTE_OFF, pool[2'($urandom_range(0, 3))],
                      VEL_W'($urandom_range(0, 127)), next_beat());
         else if (r == 8)
            queue_msg(ACT_MIDI, KIND_NOTE_ON, pool[2'($urandom_range(0, 3))], '0,
                      next_beat());
         else
            queue_msg(ACT_MIDI, KIND_NOTE_OFF, PITCH_W'($urandom_range(0, 127)),
                      VEL_W'($urandom_range(0, 127)), next_beat());
      end
      if ($urandom_range(0, 4) != 0)
         queue_msg(ACT_STOP, 2'($urandom_range(0, 3)), PITCH_W'($urandom_range(0, 127)),
                   VEL_W'($urandom_range(0, 127)), next_beat());
   endtask

   // Wait until every message is taken and every note has come back.
   task automatic wait_drained();
      while (msg_queue.size() > 0 || req_tvalid || notes_expected.size() > 0)
         @(posedge clock);
   endtask

   // The register is only written once the unit has had time to go idle.
   task automatic write_min_duration(input logic [MIN_DUR_W-1:0] v);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      min_dur = v;
   endtask

   task automatic run_random_phase(input int target);
      int goal;
      goal = planned - noise_planned + target;
      while (planned - noise_planned < goal) begin
         case ($urandom_range(0, 9))
            0: queue_session(1'b1);
            1, 2, 3, 4, 5, 6: queue_session(1'b0);
            default: begin
               noise_planned++;
               queue_msg(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         PITCH_W'($urandom_range(0, 127)),
                         VEL_W'($urandom_range(0, 127)), $urandom);
            end
         endcase
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed corner cases, under the reset value of min_duration.
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd60, 7'd100, 32'd10);   // not armed yet
      queue_msg(ACT_STOP, KIND_NOTE_ON, 7'd0, 7'd0, 32'd20);      // stop while idle
      queue_msg(ACT_START, KIND_NOTE_ON, 7'd0, 7'd0, 32'd0);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd0, 7'd127, 32'd0);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd127, 7'd1, 32'hFFFF_FFFF);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd60, 7'd64, 32'd100);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd60, 7'd65, 32'd200);
      // Time running backwards against the newest pitch 60.
      queue_msg(ACT_MIDI, KIND_NOTE_OFF, 7'd60, 7'd0, 32'd150);
      // Zero-velocity note-on closes the older pitch 60.
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd60, 7'd0, 32'h0001_0000);
      queue_msg(ACT_MIDI, KIND_NOTE_OFF, 7'd5, 7'd127, 32'h0002_0000);  // no match
      queue_msg(ACT_MIDI, KIND_OTHER, 7'd0, 7'd127, 32'h0002_0000);
      queue_msg(ACT_MIDI, KIND_UNUSED, 7'd127, 7'd127, 32'h0002_0000);
      queue_msg(ACT_UNUSED, KIND_NOTE_OFF, 7'd127, 7'd1, 32'hFFFF_FFFF);
      // Start while armed empties the table.
      queue_msg(ACT_START, KIND_UNUSED, 7'd127, 7'd127, 32'hFFFF_FFFF);
      queue_msg(ACT_MIDI, KIND_NOTE_OFF, 7'd0, 7'd0, 32'h0003_0000);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd10, 7'd42, 32'h0003_0000);
      queue_msg(ACT_MIDI, KIND_NOTE_OFF, 7'd10, 7'd0, 32'h0003_0001);  // short note
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd20, 7'd30, 32'd1000);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd21, 7'd31, 32'd2000);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd127, 7'd127, 32'h8000_0000);
      queue_msg(ACT_STOP, KIND_NOTE_OFF, 7'd0, 7'd0, 32'hFFFF_FFFF);
      queue_msg(ACT_MIDI, KIND_NOTE_OFF, 7'd20, 7'd0, 32'hFFFF_FFFF);  // disarmed
      run_random_phase(PHASE_ITEMS / 2);

      // Random sessions across the range of min_duration.
      write_min_duration('0);
      queue_msg(ACT_START, KIND_NOTE_ON, 7'd0, 7'd0, 32'd0);
      queue_msg(ACT_MIDI, KIND_NOTE_ON, 7'd33, 7'd9, 32'd500);
      queue_msg(ACT_MIDI, KIND_NOTE_OFF, 7'd33, 7'd9, 32'd500);         // zero length
      run_random_phase(PHASE_ITEMS);
      write_min_duration('1);
      run_random_phase(PHASE_ITEMS);
      write_min_duration(MIN_DUR_W'($urandom));
      run_random_phase(PHASE_ITEMS);
      write_min_duration(16'd1);
      run_random_phase(PHASE_ITEMS);
      write_min_duration(MIN_DUR_RESET);
      wait_drained();
      calm = 1'b1;
      run_random_phase(PHASE_ITEMS / 2);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (notes_expected.size() > 0) begin
         $error("%0d expected notes never arrived", notes_expected.size());
         failures++;
      end
      $display("Run took %0d messages and returned %0d notes: %0d flushed on stop,",
               msgs_taken, notes_seen, notes_flushed);
      $display("%0d note-ons dropped on a full table, over six min_duration settings.",
               notes_dropped);
      if (failures == 0)
         $display("midi_note_pairing_table_unit verification clean");
      else
         $display("midi_note_pairing_table_unit verification failed");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("midi_note_pairing_table_unit verification failed");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/mnp_pkg.sv
hw/rtl/mnp_ram.sv
hw/rtl/mnp_seq.sv
hw/rtl/midi_note_pairing_table_unit.sv
hw/rtl/mnp_checker.sv
tb/tb.sv
